>>> hdl/dws_pkg.sv
package dws_pkg;

  // register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_DRIVE  = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_MIX    = 2'd3;

  // shaper modes
  localparam logic [1:0] MODE_SOFT     = 2'd0;
  localparam logic [1:0] MODE_HARD     = 2'd1;
  localparam logic [1:0] MODE_FUZZ     = 2'd2;
  localparam logic [1:0] MODE_SOFT_ALT = 2'd3;

  // full scale of the percent registers
  localparam logic [6:0] PCT_FULL = 7'd100;

  // pipeline depth of each part
  localparam int PRE_STAGES = 3;
  localparam int SHP_STAGES = 5;
  localparam int MIX_STAGES = 4;

  // configuration as seen by the datapath
  typedef struct packed {
    logic       enable;
    logic [6:0] drive;
    logic [1:0] mode;
    logic [6:0] mix;
  } cfg_t;

endpackage

>>> hdl/dws_pregain.sv
module dws_pregain #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic [dws_pkg::PRE_STAGES-1:0]      en_i,
  input  dws_pkg::cfg_t                       cfg_i,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  output logic signed [SAMPLE_BITS-1:0]       x_o,
  output logic                                neg_o,
  output logic [SAMPLE_BITS+2:0]              u_o
);

  localparam int GW = 23;
  localparam int UW = SAMPLE_BITS + 3;
  localparam int PW = SAMPLE_BITS + GW;
  localparam int RW = PW - 15;
  localparam logic [UW-1:0] U_MAX = {1'b1, {(UW-1){1'b0}}};

  typedef logic [GW-1:0] gain_tab_t [101];

  // pregain 10^(0.04*d) in Q7.16, saturating
  function automatic gain_tab_t build_gain();
    logic [63:0] g;
    logic [63:0] v;
    gain_tab_t   tab;
    g = 64'd1 << 28;
    for (int d = 0; d < 101; d++) begin
      v = (g + 64'd2048) >> 12;
      tab[d] = (v > 64'h7FFFFF) ? 23'h7FFFFF : v[GW-1:0];
      if (g < (64'd128 << 28)) begin
        g = (g * 64'd294333625 + (64'd1 << 27)) >> 28;
      end
    end
    return tab;
  endfunction

  localparam gain_tab_t GAIN_TAB = build_gain();

  logic [6:0]             dsel;
  logic [SAMPLE_BITS-1:0] mag_d;
  logic [RW-1:0]          r_d;

  logic signed [SAMPLE_BITS-1:0] x0_q, x1_q, x2_q;
  logic                          neg0_q, neg1_q, neg2_q;
  logic [SAMPLE_BITS-1:0]        mag0_q;
  logic [GW-1:0]                 g0_q;
  logic [PW-1:0]                 p1_q;
  logic [UW-1:0]                 u2_q;

  // drive clamp and magnitude
  always_comb begin
    dsel  = (cfg_i.drive > dws_pkg::PCT_FULL) ? dws_pkg::PCT_FULL : cfg_i.drive;
    mag_d = x_i[SAMPLE_BITS-1] ? (~x_i + 1'b1) : x_i;
  end

  // stage 0: gain table lookup
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x0_q   <= x_i;
      neg0_q <= x_i[SAMPLE_BITS-1];
      mag0_q <= mag_d;
      g0_q   <= GAIN_TAB[dsel];
    end
  end

  // stage 1: gain multiply
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x1_q   <= x0_q;
      neg1_q <= neg0_q;
      p1_q   <= PW'(mag0_q) * PW'(g0_q);
    end
  end

  // stage 2: round and cap at 8.0
  assign r_d = RW'((p1_q + PW'(32768)) >> 16);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x2_q   <= x1_q;
      neg2_q <= neg1_q;
      u2_q   <= (r_d > RW'(U_MAX)) ? U_MAX : r_d[UW-1:0];
    end
  end

  assign x_o   = x2_q;
  assign neg_o = neg2_q;
  assign u_o   = u2_q;

endmodule

>>> hdl/dws_shaper.sv
module dws_shaper #(
  parameter int SAMPLE_BITS        = 24,
  parameter int SHAPER_TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic [dws_pkg::SHP_STAGES-1:0]      en_i,
  input  dws_pkg::cfg_t                       cfg_i,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  input  logic                                neg_i,
  input  logic [SAMPLE_BITS+2:0]              u_i,
  output logic signed [SAMPLE_BITS-1:0]       x_o,
  output logic signed [SAMPLE_BITS:0]         wet_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int FB  = SB - 1;
  localparam int SH  = SB + 2;
  localparam int UW  = SB + 3;
  localparam int IW  = $clog2(SHAPER_TABLE_DEPTH + 1);
  localparam int PIW = UW + IW;
  localparam int MW  = SB + SH;
  localparam logic [IW-1:0] I_LAST = IW'(SHAPER_TABLE_DEPTH);
  localparam logic [SB-1:0] ONE    = {1'b1, {(SB-1){1'b0}}};

  localparam int KIND_TANH  = 0;
  localparam int KIND_FUZZP = 1;
  localparam int KIND_TANH2 = 2;

  typedef logic [SB-1:0] rom_t [SHAPER_TABLE_DEPTH+1];

  // shift-subtract quotient, used only while building the tables
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] qt;
    logic [63:0] rm;
    qt = '0;
    rm = '0;
    for (int j = 63; j >= 0; j--) begin
      rm = {rm[62:0], a[j]};
      if (rm >= b) begin
        rm    = rm - b;
        qt[j] = 1'b1;
      end
    end
    return qt;
  endfunction

  // shaper points over [0,8] from the exp(-h) recurrence
  function automatic rom_t build_rom(input int kind);
    logic [63:0] h;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] sc;
    rom_t        tab;
    h = udiv((64'd1 << 34) + 64'(SHAPER_TABLE_DEPTH / 2), 64'(SHAPER_TABLE_DEPTH));
    t = 64'd1 << 31;
    q = 64'd1 << 31;
    for (int n = 1; n <= 15; n++) begin
      t = (t * h + (64'd1 << 30)) >> 31;
      t = udiv(t + 64'(n / 2), 64'(n));
      if ((n % 2) == 1) q = q - t;
      else q = q + t;
    end
    e = 64'd1 << 31;
    for (int k = 0; k <= 4 * SHAPER_TABLE_DEPTH; k++) begin
      num = (64'd1 << 31) - e;
      den = (64'd1 << 31) + e;
      if (FB == 31) sc = e;
      else sc = (e + (64'd1 << (30 - FB))) >> (31 - FB);
      if (kind == KIND_FUZZP && k <= SHAPER_TABLE_DEPTH) begin
        tab[k] = SB'((64'd1 << FB) - sc);
      end
      if (kind == KIND_TANH && (k % 2) == 0 && (k / 2) <= SHAPER_TABLE_DEPTH) begin
        tab[k/2] = SB'(udiv((num << FB) + den / 2, den));
      end
      if (kind == KIND_TANH2 && (k % 4) == 0) begin
        tab[k/4] = SB'(udiv((num << FB) + den / 2, den));
      end
      e = (e * q + (64'd1 << 30)) >> 31;
    end
    return tab;
  endfunction

  localparam rom_t TANH_ROM  = build_rom(KIND_TANH);
  localparam rom_t FUZZP_ROM = build_rom(KIND_FUZZP);
  localparam rom_t TANH2_ROM = build_rom(KIND_TANH2);

  logic [PIW-1:0] p_d;
  logic [IW-1:0]  a0, a1;
  logic [SB-1:0]  sel0, sel1;
  logic [MW-1:0]  rnd_d;
  logic [SB-1:0]  w_d;

  logic signed [SB-1:0] x3_q, x4_q, x5_q, x6_q, x7_q;
  logic                 neg3_q, neg4_q, neg5_q, neg6_q;
  logic [UW-1:0]        u3_q, u4_q;
  logic [IW-1:0]        i3_q;
  logic [SH-1:0]        fr3_q, fr4_q, fr5_q;
  logic                 sat4_q;
  logic [SB-1:0]        ta0_q, ta1_q, tb0_q, tb1_q, tc0_q, tc1_q;
  logic [SB-1:0]        t05_q, d5_q, hard5_q, t06_q, hard6_q;
  logic [MW-1:0]        prod6_q;
  logic signed [SB:0]   wet7_q;

  // stage 3: table index and fraction
  assign p_d = PIW'(u_i) * PIW'(SHAPER_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x3_q   <= x_i;
      neg3_q <= neg_i;
      u3_q   <= u_i;
      i3_q   <= IW'(p_d >> SH);
      fr3_q  <= p_d[SH-1:0];
    end
  end

  // stage 4: registered reads of both neighbor points
  assign a0 = i3_q;
  assign a1 = (i3_q == I_LAST) ? i3_q : i3_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ta0_q  <= TANH_ROM[a0];
      ta1_q  <= TANH_ROM[a1];
      tb0_q  <= FUZZP_ROM[a0];
      tb1_q  <= FUZZP_ROM[a1];
      tc0_q  <= TANH2_ROM[a0];
      tc1_q  <= TANH2_ROM[a1];
      sat4_q <= (i3_q == I_LAST);
      fr4_q  <= fr3_q;
      x4_q   <= x3_q;
      neg4_q <= neg3_q;
      u4_q   <= u3_q;
    end
  end

  // stage 5: pick the curve, slope and hard clip
  always_comb begin
    unique case (cfg_i.mode)
      dws_pkg::MODE_FUZZ: begin
        sel0 = neg4_q ? tc0_q : tb0_q;
        sel1 = neg4_q ? tc1_q : tb1_q;
      end
      dws_pkg::MODE_SOFT, dws_pkg::MODE_SOFT_ALT, dws_pkg::MODE_HARD: begin
        sel0 = ta0_q;
        sel1 = ta1_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      t05_q   <= sel0;
      d5_q    <= sat4_q ? '0 : sel1 - sel0;
      hard5_q <= (u4_q > UW'(ONE)) ? ONE : u4_q[SB-1:0];
      fr5_q   <= fr4_q;
      x5_q    <= x4_q;
      neg5_q  <= neg4_q;
    end
  end

  // stage 6: interpolation multiply
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      prod6_q <= MW'(d5_q) * MW'(fr5_q);
      t06_q   <= t05_q;
      hard6_q <= hard5_q;
      x6_q    <= x5_q;
      neg6_q  <= neg5_q;
    end
  end

  // stage 7: round, add base point (or take the hard clip in hard mode), apply sign
  assign rnd_d = (prod6_q + (MW'(1) << (SH - 1))) >> SH;
  assign w_d   = (cfg_i.mode == dws_pkg::MODE_HARD) ? hard6_q : t06_q + rnd_d[SB-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      wet7_q <= neg6_q ? -$signed({1'b0, w_d}) : $signed({1'b0, w_d});
      x7_q   <= x6_q;
    end
  end

  assign x_o   = x7_q;
  assign wet_o = wet7_q;

endmodule

>>> hdl/dws_mix.sv
module dws_mix #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic [dws_pkg::MIX_STAGES-1:0]      en_i,
  input  dws_pkg::cfg_t                       cfg_i,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  input  logic signed [SAMPLE_BITS:0]         wet_i,
  output logic [SAMPLE_BITS-1:0]              y_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = SB + 8;
  localparam int AW = SB + 6;
  localparam int QW = 2 * AW;
  localparam logic [63:0]   RCP64  = (64'd1 << AW) / 64'd100;
  localparam logic [AW-1:0] RCP    = RCP64[AW-1:0];
  localparam logic [AW-1:0] DIV    = AW'(100);
  localparam logic [AW-1:0] HALF   = AW'(50);
  localparam logic [AW-1:0] MAXPOS = AW'({1'b0, {(SB-1){1'b1}}});

  logic [6:0]           m, mc;
  logic signed [CW-1:0] acc_d;
  logic [CW-1:0]        mag_d;
  logic [AW-1:0]        q0, rem, q;
  logic                 bypass;

  logic signed [CW-1:0] acc8_q;
  logic signed [SB-1:0] x8_q, x9_q, x10_q;
  logic [AW-1:0]        a9_q, a10_q;
  logic                 an9_q, an10_q;
  logic [QW-1:0]        pq10_q;
  logic [SB-1:0]        y11_q;

  // stage 8: dry/wet weighted sum
  always_comb begin
    m     = (cfg_i.mix > dws_pkg::PCT_FULL) ? dws_pkg::PCT_FULL : cfg_i.mix;
    mc    = dws_pkg::PCT_FULL - m;
    acc_d = CW'(x_i) * $signed({{(CW-7){1'b0}}, mc})
          + CW'(wet_i) * $signed({{(CW-7){1'b0}}, m});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      acc8_q <= acc_d;
      x8_q   <= x_i;
    end
  end

  // stage 9: magnitude plus half divisor
  assign mag_d = acc8_q[CW-1] ? CW'(-acc8_q) : CW'(acc8_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a9_q  <= mag_d[AW-1:0] + HALF;
      an9_q <= acc8_q[CW-1];
      x9_q  <= x8_q;
    end
  end

  // stage 10: reciprocal multiply for the divide by 100
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pq10_q <= QW'(a9_q) * QW'(RCP);
      a10_q  <= a9_q;
      an10_q <= an9_q;
      x10_q  <= x9_q;
    end
  end

  // stage 11: quotient correction, sign, saturation, bypass
  always_comb begin
    q0     = pq10_q[QW-1:AW];
    rem    = a10_q - AW'(q0 * DIV);
    q      = (rem >= DIV) ? q0 + 1'b1 : q0;
    bypass = !cfg_i.enable || (cfg_i.drive == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      if (bypass) begin
        y11_q <= x10_q;
      end else if (an10_q) begin
        y11_q <= SB'(~q + 1'b1);
      end else begin
        y11_q <= (q > MAXPOS) ? MAXPOS[SB-1:0] : q[SB-1:0];
      end
    end
  end

  assign y_o = y11_q;

endmodule

>>> hdl/stereo_waveshaper_distortion.sv
// channel   role             handshake                  payload
// s_axis    stereo in        tvalid/tready              tdata: in_left, in_right
// m_axis    stereo out       tvalid/tready              tdata: out_left, out_right
// apb       config regs      psel/penable, pready = 1   enable, drive, mode, mix
//
// one stereo pair per cycle sustained while m_axis_tready is high; pairs pass through
// the pipeline (gain table and multiply, shaper table reads and interpolation multiply,
// mix multiply and reciprocal divide), each stage carrying its own valid bit.
// rst_ni clears the valid bits and resets the configuration registers; data
// registers are not reset and tables are constant roms.
// a stalled output only holds the stages that are full: empty stages fill.
module stereo_waveshaper_distortion #(
  parameter int SAMPLE_BITS        = 24,
  parameter int SHAPER_TABLE_DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // in_left, in_right, zero fill
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // out_left, out_right, zero fill
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [3:0]                               paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int TW = ((2 * SB + 7) / 8) * 8;
  localparam int P0 = dws_pkg::PRE_STAGES;
  localparam int S0 = dws_pkg::SHP_STAGES;
  localparam int NS = P0 + S0 + dws_pkg::MIX_STAGES;

  logic [6:0]   drive_q, mix_q;
  logic [1:0]   mode_q;
  logic         enable_q;
  logic         wr;
  dws_pkg::cfg_t cfg;

  logic [NS-1:0] v_q;
  logic [NS:0]   en_w;

  // configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      drive_q  <= '0;
      mode_q   <= dws_pkg::MODE_SOFT;
      mix_q    <= dws_pkg::PCT_FULL;
    end else if (wr) begin
      unique case (paddr[3:2])
        dws_pkg::REG_ENABLE: enable_q <= pwdata[0];
        dws_pkg::REG_DRIVE:  drive_q  <= pwdata[6:0];
        dws_pkg::REG_MODE:   mode_q   <= pwdata[1:0];
        dws_pkg::REG_MIX:    mix_q    <= pwdata[6:0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      dws_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
      dws_pkg::REG_DRIVE:  prdata = {25'd0, drive_q};
      dws_pkg::REG_MODE:   prdata = {30'd0, mode_q};
      dws_pkg::REG_MIX:    prdata = {25'd0, mix_q};
    endcase
  end

  assign cfg = '{enable: enable_q, drive: drive_q, mode: mode_q, mix: mix_q};

  // per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en_w[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      en_w[k] = !v_q[k] || en_w[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_w[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en_w[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = en_w[0];
  assign m_axis_tvalid = v_q[NS-1];

  // two identical channel pipelines
  logic signed [SB-1:0] x_in [2];
  logic signed [SB-1:0] x_pre [2];
  logic signed [SB-1:0] x_shp [2];
  logic                 neg_pre [2];
  logic [SB+2:0]        u_pre [2];
  logic signed [SB:0]   wet [2];
  logic [SB-1:0]        y [2];

  assign x_in[0] = s_axis_tdata[SB-1:0];
  assign x_in[1] = s_axis_tdata[2*SB-1:SB];

  for (genvar c = 0; c < 2; c++) begin : g_ch
    dws_pregain #(.SAMPLE_BITS(SB)) u_pre_i (
      .clk_i (clk_i),
      .en_i  (en_w[P0-1:0]),
      .cfg_i (cfg),
      .x_i   (x_in[c]),
      .x_o   (x_pre[c]),
      .neg_o (neg_pre[c]),
      .u_o   (u_pre[c])
    );

    dws_shaper #(.SAMPLE_BITS(SB), .SHAPER_TABLE_DEPTH(SHAPER_TABLE_DEPTH)) u_shp_i (
      .clk_i (clk_i),
      .en_i  (en_w[P0+S0-1:P0]),
      .cfg_i (cfg),
      .x_i   (x_pre[c]),
      .neg_i (neg_pre[c]),
      .u_i   (u_pre[c]),
      .x_o   (x_shp[c]),
      .wet_o (wet[c])
    );

    dws_mix #(.SAMPLE_BITS(SB)) u_mix_i (
      .clk_i (clk_i),
      .en_i  (en_w[NS-1:P0+S0]),
      .cfg_i (cfg),
      .x_i   (x_shp[c]),
      .wet_i (wet[c]),
      .y_o   (y[c])
    );
  end

  assign m_axis_tdata = TW'({y[1], y[0]});

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> s_axis_tready)
    else $error("input not ready with empty output stage");

  a_full_when_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&v_q))
    else $error("input stalled while a stage is empty");

  a_mid_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[P0+1] && !en_w[P0+1]) |=> v_q[P0+1])
    else $error("held item dropped inside the pipeline");
`endif

endmodule
